>>> rtl/kclw_pkg.sv
// Shared types and constants for the keyboard to character LCD writer.
`default_nettype none

package kclw_pkg;

	// Input kinds carried on the slave-side tuser bit.
	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_INIT = 1'b1;

	// Special key codes.
	localparam logic [7:0] KEY_HALT      = 8'd3;
	localparam logic [7:0] KEY_NEWLINE   = 8'd10;
	localparam logic [7:0] KEY_BACKSPACE = 8'd127;

	// LCD command and character values.
	localparam logic [7:0] LCD_HOME         = 8'h02;
	localparam logic [7:0] LCD_CLEAR        = 8'h01;
	localparam logic [7:0] LCD_FUNC_SET     = 8'h20;
	localparam logic [7:0] LCD_DISP_CTRL    = 8'h0F;
	localparam logic [7:0] LCD_CURSOR_LEFT  = 8'h10;
	localparam logic [7:0] LCD_SHIFT_LEFT   = 8'h18;
	localparam logic [7:0] LCD_SHIFT_RIGHT  = 8'h1C;
	localparam logic [7:0] LCD_SPACE        = 8'h20;

	// Expander control bits in the low nibble.
	localparam logic BL_ON = 1'b1;

	// Wait times in microseconds.
	localparam logic [11:0] DELAY_NONE  = 12'd0;
	localparam logic [11:0] DELAY_SHORT = 12'd50;
	localparam logic [11:0] DELAY_LONG  = 12'd2050;

	// Queue between the front and the back.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;

	// One LCD byte to send as two nibbles.
	typedef struct packed {
		logic [7:0] value;
		logic       rs;
		logic       long_wait;
	} pair_t;

	// Everything one input item sends: up to four LCD bytes.
	typedef struct packed {
		pair_t [3:0] pairs;
		logic  [1:0] last_idx;
	} entry_t;

	// Front status seen by the top level.
	typedef struct packed {
		logic halted;
	} front_status_t;

	function automatic pair_t mk_pair(logic [7:0] value, logic rs, logic long_wait);
		pair_t p;
		p.value     = value;
		p.rs        = rs;
		p.long_wait = long_wait;
		return p;
	endfunction

endpackage

`default_nettype wire

>>> rtl/kclw_front.sv
// Front part: accepts key and init requests, tracks the column and builds LCD byte lists.
`default_nettype none

module kclw_front #(
	parameter int unsigned VISIBLE_COLS = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  wire                    in_cmd,
	input  wire  [7:0]             in_key,
	input  wire                    q_full,
	output logic                   in_ready,
	output logic                   push,
	output kclw_pkg::entry_t       push_entry,
	output kclw_pkg::front_status_t status
);

	localparam logic [7:0] THR = 8'(VISIBLE_COLS - 1);

	logic       halted_q;
	logic [7:0] col_q;
	logic       accept;
	logic [2:0] n;
	logic       inc_col;
	logic       dec_col;
	logic       set_halt;
	logic       is_bs;

	assign in_ready      = !q_full;
	assign accept        = in_valid && in_ready;
	assign status.halted = halted_q;
	assign is_bs         = (in_key == kclw_pkg::KEY_BACKSPACE);

	// Build the list of LCD bytes that this request causes.
	always_comb begin
		push_entry = '0;
		n          = '0;
		inc_col    = 1'b0;
		dec_col    = 1'b0;
		set_halt   = 1'b0;
		if (in_cmd == kclw_pkg::CMD_INIT) begin
			push_entry.pairs[0] = kclw_pkg::mk_pair(kclw_pkg::LCD_HOME, 1'b0, 1'b1);
			push_entry.pairs[1] = kclw_pkg::mk_pair(kclw_pkg::LCD_CLEAR, 1'b0, 1'b1);
			push_entry.pairs[2] = kclw_pkg::mk_pair(kclw_pkg::LCD_FUNC_SET, 1'b0, 1'b0);
			push_entry.pairs[3] = kclw_pkg::mk_pair(kclw_pkg::LCD_DISP_CTRL, 1'b0, 1'b0);
			n = 3'd4;
		end else if (in_key == kclw_pkg::KEY_HALT) begin
			set_halt = 1'b1;
		end else begin
			// Scroll the display while the cursor is at or past the visible edge; a backspace scrolls back only past it.
			if (col_q >= THR) begin
				if (is_bs) begin
					if (col_q != THR) begin
						push_entry.pairs[n[1:0]] =
							kclw_pkg::mk_pair(kclw_pkg::LCD_SHIFT_RIGHT, 1'b0, 1'b0);
						n = n + 3'd1;
					end
				end else begin
					push_entry.pairs[n[1:0]] =
						kclw_pkg::mk_pair(kclw_pkg::LCD_SHIFT_LEFT, 1'b0, 1'b0);
					n = n + 3'd1;
				end
			end
			if (is_bs) begin
				if (col_q != 8'd0) begin
					push_entry.pairs[n[1:0]] =
						kclw_pkg::mk_pair(kclw_pkg::LCD_CURSOR_LEFT, 1'b0, 1'b0);
					n = n + 3'd1;
					push_entry.pairs[n[1:0]] =
						kclw_pkg::mk_pair(kclw_pkg::LCD_SPACE, 1'b1, 1'b0);
					n = n + 3'd1;
					push_entry.pairs[n[1:0]] =
						kclw_pkg::mk_pair(kclw_pkg::LCD_CURSOR_LEFT, 1'b0, 1'b0);
					n = n + 3'd1;
					dec_col = 1'b1;
				end
			end else if (in_key != kclw_pkg::KEY_NEWLINE) begin
				push_entry.pairs[n[1:0]] = kclw_pkg::mk_pair(in_key, 1'b1, 1'b0);
				n = n + 3'd1;
				inc_col = (col_q != 8'd255);
			end
		end
		push_entry.last_idx = 2'(n - 3'd1);
	end

	assign push = accept && !halted_q && (n != 3'd0);

	// Column counter and halt flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
			col_q    <= 8'd0;
		end else if (accept && !halted_q) begin
			if (set_halt) begin
				halted_q <= 1'b1;
			end
			if (inc_col) begin
				col_q <= col_q + 8'd1;
			end else if (dec_col) begin
				col_q <= col_q - 8'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/kclw_queue.sv
// Short queue of LCD byte lists between the front and the back.
`default_nettype none

module kclw_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  kclw_pkg::entry_t  push_entry,
	input  wire               pop,
	output logic              full,
	output logic              valid,
	output kclw_pkg::entry_t  head
);

	kclw_pkg::entry_t               mem_q [kclw_pkg::QDEPTH];
	logic [kclw_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [kclw_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [kclw_pkg::QPTR_W:0]      count_q;

	assign full  = (count_q == (kclw_pkg::QPTR_W+1)'(kclw_pkg::QDEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (kclw_pkg::QPTR_W)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (kclw_pkg::QPTR_W)'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (kclw_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (kclw_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/kclw_back.sv
// Back part: expands each LCD byte into six expander writes with wait times.
`default_nettype none

module kclw_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_valid,
	input  kclw_pkg::entry_t  q_head,
	output logic              pop,
	output logic              m_valid,
	input  wire               m_ready,
	output logic [7:0]        m_byte,
	output logic [11:0]       m_delay,
	output logic              m_last
);

	kclw_pkg::entry_t cur_q;
	logic             busy_q;
	logic [1:0]       pair_q;
	logic [2:0]       byte_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [11:0]      out_delay_q;
	logic             out_last_q;

	kclw_pkg::pair_t  p;
	logic             hi_half;
	logic [1:0]       sub;
	logic [3:0]       nib;
	logic [7:0]       gen_byte;
	logic [11:0]      gen_delay;
	logic             pair_end;
	logic             gen_last;
	logic             adv;

	// Write currently in hand.
	always_comb begin
		p        = cur_q.pairs[pair_q];
		hi_half  = (byte_q < 3'd3);
		sub      = hi_half ? byte_q[1:0] : 2'(byte_q - 3'd3);
		nib      = hi_half ? p.value[7:4] : p.value[3:0];
		gen_byte = {nib, kclw_pkg::BL_ON, (sub == 2'd1), 1'b0, p.rs};
		pair_end = (byte_q == 3'd5);
		case (sub)
			2'd0:    gen_delay = kclw_pkg::DELAY_NONE;
			2'd1:    gen_delay = kclw_pkg::DELAY_SHORT;
			default: gen_delay = (pair_end && p.long_wait) ? kclw_pkg::DELAY_LONG
			                                               : kclw_pkg::DELAY_SHORT;
		endcase
		gen_last = pair_end && (pair_q == cur_q.last_idx);
	end

	assign adv = busy_q && (!out_valid_q || m_ready);
	assign pop = q_valid && (!busy_q || (adv && gen_last));

	// Sequencer over pairs and writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pair_q      <= '0;
			byte_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				pair_q <= '0;
				byte_q <= '0;
			end else if (adv) begin
				if (gen_last) begin
					busy_q <= 1'b0;
				end else if (pair_end) begin
					pair_q <= pair_q + 2'd1;
					byte_q <= '0;
				end else begin
					byte_q <= byte_q + 3'd1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
		if (adv) begin
			out_byte_q  <= gen_byte;
			out_delay_q <= gen_delay;
			out_last_q  <= gen_last;
		end
	end

	assign m_valid = out_valid_q;
	assign m_byte  = out_byte_q;
	assign m_delay = out_delay_q;
	assign m_last  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/keyboard_to_char_lcd_writer_core.sv
// Top level of the keyboard to character LCD writer.
`default_nettype none

// Converts typed key codes and init requests into the write stream for an
// I2C port expander driving a character LCD in 4-bit mode. Each LCD byte
// becomes six expander writes, and a request causes 0 to 24 writes; the
// last one carries tlast. The front takes one request per cycle while its
// four-entry queue has room. The back emits one write per cycle while
// m_axis_tready is high and it has an entry in hand; init causes 24 writes.
// After the halt key every later request is taken and dropped until reset.
module keyboard_to_char_lcd_writer_core #(
	parameter int unsigned VISIBLE_COLS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,  // [7:0] key_code
	input  wire         s_axis_tuser,  // [0] cmd
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] expander_byte, [19:8] delay_us, [23:20] zero
	output logic        m_axis_tlast
);

	logic                     q_push;
	logic                     q_pop;
	logic                     q_full;
	logic                     q_valid;
	kclw_pkg::entry_t         q_in;
	kclw_pkg::entry_t         q_head;
	kclw_pkg::front_status_t  status;
	logic [7:0]               out_byte;
	logic [11:0]              out_delay;

	kclw_front #(
		.VISIBLE_COLS(VISIBLE_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_key    (s_axis_tdata),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (q_push),
		.push_entry(q_in),
		.status    (status)
	);

	kclw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_in),
		.pop       (q_pop),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head)
	);

	kclw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (q_pop),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_byte  (out_byte),
		.m_delay (out_delay),
		.m_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, out_delay, out_byte};

`ifndef SYNTHESIS
	// The front never writes into a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	// The back only takes entries that are present.
	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue read while empty");

	// Once halted, the block stays halted and queues nothing new.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.halted |=> (status.halted && !q_push))
		else $error("halt state lost or request queued while halted");
`endif

endmodule

`default_nettype wire
